// ===== hdl/fnv1a_64_with_final_mix_unit_macros.svh =====
// ----------------------------------------------------------------------------
// FNV-1a 64 hash unit assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FNV1A_64_WITH_FINAL_MIX_UNIT_MACROS_SVH
`define FNV1A_64_WITH_FINAL_MIX_UNIT_MACROS_SVH

// same-cycle implication
`define FNV_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FNV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fnv1a_pkg.sv =====
// ----------------------------------------------------------------------------
// FNV-1a 64 hash package
// Constants and sequencer types for the FNV-1a 64 hash unit with fmix64.
// ----------------------------------------------------------------------------
`default_nettype none

package fnv1a_pkg;

    localparam logic [63:0] FNV_OFFSET_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME_64     = 64'h00000100000001B3;
    localparam logic [63:0] MIX_MUL_A        = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] MIX_MUL_B        = 64'hC4CEB9FE1A85EC53;
    localparam int unsigned MIX_SHIFT        = 33;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_XSHIFT
    } state_t;

    // which multiply the shared unit is working on
    typedef enum logic [1:0] {
        PH_FNV,
        PH_MIXA,
        PH_MIXB
    } phase_t;

    typedef enum logic [1:0] {
        MS_LL,
        MS_LH,
        MS_HL,
        MS_SUM
    } mul_step_t;

endpackage

`default_nettype wire

// ===== hdl/fnv1a_64_with_final_mix_unit.sv =====
// ----------------------------------------------------------------------------
// FNV-1a 64 hash unit with fmix64 finalization
// Byte-serial FNV-1a 64 hash; the closing transaction runs murmur3 fmix64.
// ----------------------------------------------------------------------------
// A byte transaction is accepted, then runs a 4-step 64x64 mod 2^64 multiply
//   on one shared 32x32 multiplier. A last transaction adds fmix64 (XSHIFT,
//   MUL, XSHIFT, MUL, XSHIFT) before the result is shown in the output
//   register; the final step waits only while an earlier result is still
//   untaken. One input transaction at a time.
// Reset (async, rst_n low): running hash = offset basis, sequencer idle.
`default_nettype none
`include "fnv1a_64_with_final_mix_unit_macros.svh"

module fnv1a_64_with_final_mix_unit
    import fnv1a_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] byte_present
    input  wire logic        s_axis_tlast,   // last_item
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata    // [63:0] hash_value
);

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    mul_step_t   step_reg, step_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] hash_reg, hash_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] out_reg, out_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_result;
    logic [63:0] a_xs;
    logic        s_acc;

    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    assign mul_result = acc_reg + {prod_reg[31:0], 32'd0};
    assign a_xs       = a_reg ^ (a_reg >> MIX_SHIFT);

    always_comb
    begin
        case (step_reg)
            MS_LL:   begin mul_a = a_reg[31:0];  mul_b = b_reg[31:0];  end
            MS_LH:   begin mul_a = a_reg[31:0];  mul_b = b_reg[63:32]; end
            MS_HL:   begin mul_a = a_reg[63:32]; mul_b = b_reg[31:0];  end
            default: begin mul_a = a_reg[63:32]; mul_b = b_reg[31:0];  end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_FNV;
            step_reg      <= MS_LL;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            hash_reg      <= FNV_OFFSET_BASIS;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            hash_reg      <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        hash_next      = hash_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        out_next       = out_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    last_next  = s_axis_tlast;
                    phase_next = PH_FNV;
                    step_next  = MS_LL;
                    if (s_axis_tuser)
                    begin
                        a_next     = hash_reg ^ {56'd0, s_axis_tdata};
                        b_next     = FNV_PRIME_64;
                        state_next = ST_MUL;
                    end
                    else if (s_axis_tlast)
                    begin
                        a_next     = hash_reg;
                        state_next = ST_XSHIFT;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next = {32'd0, mul_a} * {32'd0, mul_b};
                case (step_reg)
                    MS_LL:
                    begin
                        step_next = MS_LH;
                    end
                    MS_LH:
                    begin
                        acc_next  = prod_reg;
                        step_next = MS_HL;
                    end
                    MS_HL:
                    begin
                        acc_next  = mul_result;
                        step_next = MS_SUM;
                    end
                    default:
                    begin
                        step_next = MS_LL;
                        a_next    = mul_result;
                        if (phase_reg == PH_FNV)
                        begin
                            hash_next  = mul_result;
                            state_next = last_reg ? ST_XSHIFT : ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_XSHIFT;
                        end
                    end
                endcase
            end
            ST_XSHIFT:
            begin
                step_next = MS_LL;
                case (phase_reg)
                    PH_FNV:
                    begin
                        a_next     = a_xs;
                        b_next     = MIX_MUL_A;
                        phase_next = PH_MIXA;
                        state_next = ST_MUL;
                    end
                    PH_MIXA:
                    begin
                        a_next     = a_xs;
                        b_next     = MIX_MUL_B;
                        phase_next = PH_MIXB;
                        state_next = ST_MUL;
                    end
                    default:
                    begin
                        // wait here while the output register still holds a result
                        if (!out_valid_reg || m_axis_tready)
                        begin
                            out_next       = a_xs;
                            out_valid_next = 1'b1;
                            hash_next      = FNV_OFFSET_BASIS;
                            phase_next     = PH_FNV;
                            state_next     = ST_IDLE;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `FNV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `FNV_ASSERT_IMPL(a_step_idle, step_reg != MS_LL, state_reg == ST_MUL, "mul step outside MUL")
    `FNV_ASSERT_NEXT(a_empty_close, s_acc && s_axis_tlast && !s_axis_tuser,
                     state_reg == ST_XSHIFT, "empty close skipped finalize")
    `FNV_ASSERT_NEXT(a_hash_restart,
                     state_reg == ST_XSHIFT && phase_reg == PH_MIXB
                     && (!m_axis_tvalid || m_axis_tready),
                     m_axis_tvalid && hash_reg == FNV_OFFSET_BASIS,
                     "hash not restarted after finalize")

endmodule

`default_nettype wire
